@@ src/bmpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bmpc_pkg
// shared types, constants and helpers for the bernoulli mod p table check
// ----------------------------------------------------------------------------
package bmpc_pkg;

    localparam int RESIDUE_BITS = 32;
    localparam int CNT_W        = $clog2(RESIDUE_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_LOAD_W,
        ST_MUL_W,
        ST_LOAD_R,
        ST_MUL_R,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [RESIDUE_BITS-1:0] residue;
        logic                    last_item;
    } t_in_item;

    typedef struct packed {
        logic                    table_ok;
        logic [RESIDUE_BITS-1:0] final_sum;
    } t_out_item;

    // control of one serial modular unit
    typedef struct packed {
        logic load;
        logic step;
    } t_unit_ctl;

    // a, b < m
    function automatic logic [RESIDUE_BITS-1:0] add_mod(
        input logic [RESIDUE_BITS-1:0] a,
        input logic [RESIDUE_BITS-1:0] b,
        input logic [RESIDUE_BITS-1:0] m
    );
        logic [RESIDUE_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[RESIDUE_BITS-1:0];
    endfunction

endpackage

@@ src/bmpc_serial_mulmod.sv @@
// ----------------------------------------------------------------------------
// bmpc_serial_mulmod
// bit-serial modular multiply, one bit of b per step, msb first
// ----------------------------------------------------------------------------
module bmpc_serial_mulmod
    import bmpc_pkg::*;
(
    input  logic                    i_clk,
    input  t_unit_ctl               i_ctl,
    input  logic [RESIDUE_BITS-1:0] i_a,
    input  logic [RESIDUE_BITS-1:0] i_b,
    input  logic [RESIDUE_BITS-1:0] i_m,
    output logic [RESIDUE_BITS-1:0] o_acc
);

    logic [RESIDUE_BITS-1:0] r_acc;
    logic [RESIDUE_BITS-1:0] r_a;
    logic [RESIDUE_BITS-1:0] r_b;
    logic [RESIDUE_BITS-1:0] n_acc;
    logic [RESIDUE_BITS-1:0] dbl;

    // acc = 2*acc mod m, then + a mod m when the current bit is set
    always_comb begin
        dbl   = add_mod(r_acc, r_acc, i_m);
        n_acc = r_b[RESIDUE_BITS-1] ? add_mod(dbl, r_a, i_m) : dbl;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (i_ctl.step) begin
            r_acc <= n_acc;
            r_b   <= {r_b[RESIDUE_BITS-2:0], 1'b0};
        end
    end

    assign o_acc = r_acc;

endmodule

@@ src/bernoulli_mod_p_check.sv @@
// ----------------------------------------------------------------------------
// bernoulli_mod_p_check
// checks a table of bernoulli residues mod p: sum of (2i+1)*4^i*B_2i plus two
// ----------------------------------------------------------------------------
//  channel  direction  handshake                payload
//  in       input      i_in_valid / o_in_stall  t_in_item  (residue, last_item)
//  out      output     o_out_valid / i_out_stall t_out_item (table_ok, final_sum)
//  cfg      input      i_cfg_we                 i_cfg_wdata (modulus)
//
//  each in transaction keeps o_in_stall high until the block is idle again, so
//  a new transaction is only accepted once the last one is done:
//  bit-serial reduction of residue and state, then two bit-serial modular
//  multiplies on one shared unit, one bit per cycle each
//  synchronous active-low reset: modulus 3, sum 0, power and weight 1, no result
//  a held result stalls only the final cycle of the next last item
// ----------------------------------------------------------------------------
module bernoulli_mod_p_check
    import bmpc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [RESIDUE_BITS-1:0] i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_item                i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_item               o_out_data
);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RESIDUE_BITS - 1);

    // control state
    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;

    // table state and configuration
    logic [RESIDUE_BITS-1:0] r_modulus;
    logic [RESIDUE_BITS-1:0] r_running_sum;
    logic [RESIDUE_BITS-1:0] r_four_power;
    logic [RESIDUE_BITS-1:0] r_odd_weight;
    logic                    r_last;
    t_out_item               r_out_data;

    // derived modulus constants
    logic [RESIDUE_BITS-1:0] eff_m;
    logic [RESIDUE_BITS-1:0] one_mod;
    logic [RESIDUE_BITS-1:0] two_mod;

    // serial units
    t_unit_ctl               red_ctl;
    t_unit_ctl               mul_ctl;
    logic [RESIDUE_BITS-1:0] res_red;
    logic [RESIDUE_BITS-1:0] fp_red;
    logic [RESIDUE_BITS-1:0] ow_red;
    logic [RESIDUE_BITS-1:0] rs_red;
    logic [RESIDUE_BITS-1:0] mul_acc;
    logic [RESIDUE_BITS-1:0] mul_a;
    logic [RESIDUE_BITS-1:0] mul_b;

    // finishing arithmetic
    logic                    in_acc;
    logic                    cnt_done;
    logic                    out_free;
    logic                    finish_go;
    logic [RESIDUE_BITS-1:0] sum;
    logic [RESIDUE_BITS-1:0] fp_x2;
    logic [RESIDUE_BITS-1:0] fp_x4;
    logic [RESIDUE_BITS-1:0] ow_next;
    logic                    sum_ok;

    // a zero modulus behaves as modulus one
    assign eff_m   = (r_modulus == '0) ? RESIDUE_BITS'(1) : r_modulus;
    assign one_mod = (eff_m == RESIDUE_BITS'(1)) ? '0 : RESIDUE_BITS'(1);
    assign two_mod = (eff_m <= RESIDUE_BITS'(2)) ? '0 : RESIDUE_BITS'(2);

    assign in_acc    = i_in_valid && !o_in_stall;
    assign cnt_done  = (r_cnt == CNT_LAST);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign finish_go = (r_state == ST_FINISH) && (!r_last || out_free);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (cnt_done) begin
                    n_state = ST_LOAD_W;
                end
            end
            ST_LOAD_W: begin
                n_state = ST_MUL_W;
            end
            ST_MUL_W: begin
                if (cnt_done) begin
                    n_state = ST_LOAD_R;
                end
            end
            ST_LOAD_R: begin
                n_state = ST_MUL_R;
            end
            ST_MUL_R: begin
                if (cnt_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (finish_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state machine outputs
    always_comb begin
        o_in_stall   = 1'b1;
        red_ctl      = '0;
        mul_ctl      = '0;
        mul_a        = mul_acc;
        mul_b        = res_red;
        case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                red_ctl.load = i_in_valid;
            end
            ST_REDUCE: begin
                red_ctl.step = 1'b1;
            end
            ST_LOAD_W: begin
                // 4^i * (2i+1)
                mul_ctl.load = 1'b1;
                mul_a        = fp_red;
                mul_b        = ow_red;
            end
            ST_MUL_W: begin
                mul_ctl.step = 1'b1;
            end
            ST_LOAD_R: begin
                // weight times residue
                mul_ctl.load = 1'b1;
            end
            ST_MUL_R: begin
                mul_ctl.step = 1'b1;
            end
            ST_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    // residue and state values reduced mod p in parallel, a = 1 mod p
    bmpc_serial_mulmod u_red_res (
        .i_clk (i_clk),
        .i_ctl (red_ctl),
        .i_a   (one_mod),
        .i_b   (i_in_data.residue),
        .i_m   (eff_m),
        .o_acc (res_red)
    );

    bmpc_serial_mulmod u_red_fp (
        .i_clk (i_clk),
        .i_ctl (red_ctl),
        .i_a   (one_mod),
        .i_b   (r_four_power),
        .i_m   (eff_m),
        .o_acc (fp_red)
    );

    bmpc_serial_mulmod u_red_ow (
        .i_clk (i_clk),
        .i_ctl (red_ctl),
        .i_a   (one_mod),
        .i_b   (r_odd_weight),
        .i_m   (eff_m),
        .o_acc (ow_red)
    );

    bmpc_serial_mulmod u_red_rs (
        .i_clk (i_clk),
        .i_ctl (red_ctl),
        .i_a   (one_mod),
        .i_b   (r_running_sum),
        .i_m   (eff_m),
        .o_acc (rs_red)
    );

    // shared multiplier, used twice per transaction
    bmpc_serial_mulmod u_mul (
        .i_clk (i_clk),
        .i_ctl (mul_ctl),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .i_m   (eff_m),
        .o_acc (mul_acc)
    );

    // closing step: new sum, next power of four and next odd weight
    always_comb begin
        sum     = add_mod(rs_red, mul_acc, eff_m);
        fp_x2   = add_mod(fp_red, fp_red, eff_m);
        fp_x4   = add_mod(fp_x2, fp_x2, eff_m);
        ow_next = add_mod(ow_red, two_mod, eff_m);
        // sum + 2 < m + 2, so it is a multiple of m only when it equals m
        sum_ok  = (eff_m == RESIDUE_BITS'(1)) ||
                  (({1'b0, sum} + (RESIDUE_BITS+1)'(2)) == {1'b0, eff_m});
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (red_ctl.step || mul_ctl.step) begin
                r_cnt <= cnt_done ? '0 : r_cnt + CNT_W'(1);
            end
            if (finish_go && r_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // modulus and table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus     <= RESIDUE_BITS'(3);
            r_running_sum <= '0;
            r_four_power  <= RESIDUE_BITS'(1);
            r_odd_weight  <= RESIDUE_BITS'(1);
        end else begin
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
            if (finish_go) begin
                if (r_last) begin
                    // table closed, ready for the next one
                    r_running_sum <= '0;
                    r_four_power  <= RESIDUE_BITS'(1);
                    r_odd_weight  <= RESIDUE_BITS'(1);
                end else begin
                    r_running_sum <= sum;
                    r_four_power  <= fp_x4;
                    r_odd_weight  <= ow_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_last <= i_in_data.last_item;
        end
        if (finish_go && r_last) begin
            r_out_data.table_ok  <= sum_ok;
            r_out_data.final_sum <= sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ src/bmpc_checker.sv @@
// ----------------------------------------------------------------------------
// bmpc_checker
// port-level checks on the bernoulli mod p table check
// ----------------------------------------------------------------------------
module bmpc_checker
    import bmpc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // reset leaves nothing pending and the input open
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear the block");

    // an accepted transaction keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after a transaction");

    // a result never appears in the cycle after an input transaction
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result appeared too early");

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind bernoulli_mod_p_check bmpc_checker u_bmpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

@@ bench/bmpc_sum_checker.sv @@
// ----------------------------------------------------------------------------
// bmpc_sum_checker
// watches the cfg, in and out channels of the bernoulli mod p table check,
// keeps its own weighted sum, power of four and odd weight, and compares
// every result transaction with the oldest predicted table verdict
// ----------------------------------------------------------------------------
module bmpc_sum_checker
    import bmpc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [RESIDUE_BITS-1:0] i_cfg_wdata,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  t_in_item                i_in_data,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  t_out_item               i_out_data,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_tables,
    output int                      o_tables_ok
);

    logic [RESIDUE_BITS-1:0] modulus_q;
    logic [RESIDUE_BITS-1:0] sum_q;
    logic [RESIDUE_BITS-1:0] pow4_q;
    logic [RESIDUE_BITS-1:0] weight_q;
    t_out_item               table_verdicts [$];

    task automatic clear_table();
        sum_q    = '0;
        pow4_q   = RESIDUE_BITS'(1);
        weight_q = RESIDUE_BITS'(1);
    endtask

    // fold one residue into the weighted sum; a last item yields a verdict
    task automatic absorb_residue(input t_in_item item);
        longint unsigned m;
        longint unsigned r;
        longint unsigned term;
        longint unsigned total;
        t_out_item       verdict;
        m     = (modulus_q == '0) ? 64'd1 : 64'(modulus_q);
        r     = 64'(item.residue) % m;
        term  = ((64'(pow4_q) % m) * (64'(weight_q) % m)) % m;
        term  = (term * r) % m;
        total = ((64'(sum_q) % m) + term) % m;
        if (item.last_item) begin
            verdict.table_ok  = ((total + 64'd2) % m == 64'd0);
            verdict.final_sum = total[RESIDUE_BITS-1:0];
            table_verdicts.push_back(verdict);
            clear_table();
        end else begin
            sum_q    = total[RESIDUE_BITS-1:0];
            pow4_q   = RESIDUE_BITS'(((64'(pow4_q) % m) * (64'd4 % m)) % m);
            weight_q = RESIDUE_BITS'(((64'(weight_q) % m) + (64'd2 % m)) % m);
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (table_verdicts.size() == 0) begin
            $error("result with no table pending: table_ok %0b final_sum %0d",
                   got.table_ok, got.final_sum);
            o_fail_count++;
        end else begin
            want = table_verdicts.pop_front();
            o_tables++;
            if (want.table_ok) begin
                o_tables_ok++;
            end
            if (got.table_ok !== want.table_ok) begin
                $error("table_ok: expected %0b, actual %0b", want.table_ok, got.table_ok);
                o_fail_count++;
            end
            if (got.final_sum !== want.final_sum) begin
                $error("final_sum: expected %0d, actual %0d",
                       want.final_sum, got.final_sum);
                o_fail_count++;
            end
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_tables     = 0;
        o_tables_ok  = 0;
    end

    // inputs and outputs sampled as they stood before the edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            modulus_q = RESIDUE_BITS'(3);
            clear_table();
            table_verdicts.delete();
        end else begin
            if (i_cfg_we === 1'b1) begin
                modulus_q = i_cfg_wdata;
            end
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                check_result(i_out_data);
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                absorb_residue(i_in_data);
            end
        end
        o_pending <= table_verdicts.size();
    end

endmodule

@@ bench/bernoulli_mod_p_check_tb.sv @@
// ----------------------------------------------------------------------------
// bernoulli_mod_p_check_tb
// drives residue tables into the mod p table check under a range of moduli,
// with random gaps on the sender and random stalls on the receiver; a
// separate checker predicts every table verdict and counts mismatches
// ----------------------------------------------------------------------------
module bernoulli_mod_p_check_tb;
    import bmpc_pkg::*;

    // one residue takes three bit-serial passes plus the load and finish states
    localparam int     ITEM_CYCLES = 3 * RESIDUE_BITS + 3;
    // margin for a non-last residue still in flight when no verdict is owed
    localparam int     IDLE_WAIT   = ITEM_CYCLES + 24;
    // long receiver hold-off, enough for the output register to fill and the input to stall
    localparam int     HOLD_CYCLES = 1500;
    localparam int     ITEM_TARGET = 1650;
    // generous bound on the simulated time of the whole run
    localparam longint LIMIT_TIME  = 64'd30_000_000;

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [RESIDUE_BITS-1:0] cfg_wdata = '0;
    logic                    in_valid  = 1'b0;
    t_in_item                in_data   = '0;
    logic                    in_stall;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    t_out_item               out_data;

    // stimulus state
    logic [RESIDUE_BITS-1:0] cur_mod       = RESIDUE_BITS'(3);
    int                      table_left    = 0;
    int                      items_sent    = 0;
    int                      settings_done = 0;
    int                      holds_done    = 0;
    bit                      tx_burst      = 1'b0;
    bit                      rx_quiet      = 1'b0;
    bit                      short_tables  = 1'b0;
    bit                      hold_req      = 1'b0;

    // checker results
    int                      chk_fails;
    int                      chk_pending;
    int                      chk_tables;
    int                      chk_tables_ok;

    bernoulli_mod_p_check dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    bmpc_sum_checker u_sum_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (chk_fails),
        .o_pending    (chk_pending),
        .o_tables     (chk_tables),
        .o_tables_ok  (chk_tables_ok)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial begin
        #(LIMIT_TIME);
        $display("timeout: run did not finish within the time limit");
        $display("FAIL");
        $finish;
    end

    // sender gap: mostly back to back or short, now and then a long pause
    function automatic int tx_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (tx_burst || roll < 50) begin
            return 0;
        end
        if (roll < 88) begin
            return $urandom_range(1, 3);
        end
        if (roll < 98) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(30, 150);
    endfunction

    function automatic int rx_stall_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
            return $urandom_range(1, 4);
        end
        if (roll < 97) begin
            return $urandom_range(5, 15);
        end
        return $urandom_range(20, 60);
    endfunction

    // small primes dominate so that the sum-plus-two test comes out both ways;
    // the extremes of the register and a few non-primes are mixed in
    function automatic logic [RESIDUE_BITS-1:0] pick_modulus();
        logic [RESIDUE_BITS-1:0] known [14] = '{
            32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd7, 32'd11, 32'd13, 32'd31,
            32'd127, 32'd65521, 32'd2147483647, 32'd4294967291, 32'd4294967295
        };
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) begin
            return known[$urandom_range(0, 13)];
        end
        if (roll < 8) begin
            return RESIDUE_BITS'($urandom_range(3, 200) | 1);
        end
        return $urandom;
    endfunction

    // proper tables of (p-1)/2 entries where p is small, otherwise any length
    function automatic int pick_table_len();
        int roll;
        roll = $urandom_range(0, 9);
        if (short_tables) begin
            return $urandom_range(1, 2);
        end
        if (roll < 5 && cur_mod >= 3 && cur_mod <= 81 && cur_mod[0]) begin
            return int'((cur_mod - 1) / 2);
        end
        if (roll < 8) begin
            return $urandom_range(1, 8);
        end
        return $urandom_range(9, 40);
    endfunction

    // zero, all ones, just below the modulus, already reduced, or anything
    function automatic logic [RESIDUE_BITS-1:0] pick_residue();
        logic [RESIDUE_BITS-1:0] value;
        case ($urandom_range(0, 9))
            0: begin
                value = '0;
            end
            1: begin
                value = '1;
            end
            2: begin
                value = (cur_mod == '0) ? '0 : cur_mod - 1;
            end
            3, 4: begin
                value = (cur_mod == '0) ? RESIDUE_BITS'($urandom)
                                        : RESIDUE_BITS'($urandom_range(cur_mod - 1));
            end
            default: begin
                value = $urandom;
            end
        endcase
        return value;
    endfunction

    // offer one residue and hold it until the block takes it; valid stays
    // high when the next transaction follows without a gap
    task automatic send_item(input logic [RESIDUE_BITS-1:0] res, input logic last);
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{residue: res, last_item: last};
        @(posedge clk);
        while (in_stall !== 1'b0) begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // next residue of the current random table, opening a new table as needed
    task automatic send_next();
        if (table_left == 0) begin
            table_left = pick_table_len();
        end
        send_item(pick_residue(), table_left == 1);
        table_left--;
    endtask

    // all verdicts in, then time for a residue that owes no verdict to finish
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0) begin
            @(posedge clk);
        end
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    // modulus writes only ever happen with the block idle
    task automatic write_modulus(input logic [RESIDUE_BITS-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_mod = value;
        settings_done++;
    endtask

    // receiver: random stalls, quiet stretches, and one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                holds_done++;
            end else if (!rx_quiet && $urandom_range(0, 99) < 35) begin
                out_stall <= 1'b1;
                repeat (rx_stall_len()) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    initial begin
        int phase;
        int count;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset modulus 3: the one-entry table B_0 = 1 meets the test
        send_item(32'd1, 1'b1);
        // all-ones residue reduces to zero
        send_item(32'hFFFF_FFFF, 1'b1);
        send_item(32'd0, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'd2, 1'b1);

        // true table for p = 7: B_0, B_2 = 1/6, B_4 = -1/30 reduce to 1, 6, 3
        write_modulus(32'd7);
        send_item(32'd1, 1'b0);
        send_item(32'd6, 1'b0);
        send_item(32'd3, 1'b1);

        // zero modulus behaves as modulus one: everything folds to zero
        write_modulus(32'd0);
        send_item(32'hDEAD_BEEF, 1'b0);
        send_item(32'd5, 1'b1);

        // modulus one and two, no primality check in the block
        write_modulus(32'd1);
        send_item(32'd7, 1'b1);
        write_modulus(32'd2);
        send_item(32'd3, 1'b0);
        send_item(32'd1, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b1);

        // largest register value, with residues around it
        write_modulus(32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFE, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'hFFFF_FFFE, 1'b1);

        // modulus changed part way through a table
        write_modulus(32'd13);
        send_item(32'd9, 1'b0);
        send_item(32'd12, 1'b0);
        write_modulus(32'd5);
        send_item(32'd4, 1'b0);
        send_item(32'd3, 1'b1);

        // random phases; a phase may end inside a table, so the next modulus
        // then applies to the state carried across
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            write_modulus(pick_modulus());
            tx_burst     = ($urandom_range(0, 4) == 0);
            rx_quiet     = ($urandom_range(0, 4) == 0);
            short_tables = (phase == 3);
            if (short_tables) begin
                // sender keeps offering short tables while the receiver
                // holds off, so the output register fills and input stalls
                tx_burst = 1'b1;
                rx_quiet = 1'b0;
                hold_req = 1'b1;
            end
            count = $urandom_range(40, 120);
            repeat (count) send_next();
            phase++;
        end

        settle();

        $display("covered %0d residues across %0d modulus settings, %0d tables checked",
                 items_sent, settings_done, chk_tables);
        $display("%0d tables met the sum-plus-two test, %0d long receiver hold-off(s)",
                 chk_tables_ok, holds_done);
        if (chk_pending != 0) begin
            $error("%0d table verdict(s) never arrived", chk_pending);
        end
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/bmpc_pkg.sv
src/bmpc_serial_mulmod.sv
src/bernoulli_mod_p_check.sv
src/bmpc_checker.sv
bench/bmpc_sum_checker.sv
bench/bernoulli_mod_p_check_tb.sv
